// ===== design/dedup_string_pool_appender_assert.svh =====
// Assertion macros for the string pool appender.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DEDUP_STRING_POOL_APPENDER_ASSERT_SVH
`define DEDUP_STRING_POOL_APPENDER_ASSERT_SVH

// Condition and consequence checked at the same rising edge, outside reset.
`define DSPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked at the rising edge after the condition.
`define DSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dspa_pkg.sv =====
// Shared types, constants and the FNV-1a hash step for the string pool appender.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dspa_pkg;

  // FNV-1a 64-bit offset basis
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  // Field widths
  localparam int unsigned LEN_W  = 17;   // byte counts, used mark, pool size
  localparam int unsigned CNT_W  = 15;   // stored string count
  localparam int unsigned OFS_W  = 16;   // string offset
  localparam int unsigned ADDR_W = 19;   // byte address arithmetic, base + length + 2
  localparam int unsigned LIM_W  = 21;   // compares against the pool depth

  localparam logic [LEN_W-1:0] LEN_MAX        = '1;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [LEN_W-1:0] POOL_BYTES_RST = 17'd65536;

  // The pool is split into byte-wide banks by address bits [1:0]
  localparam int unsigned POOL_BANKS = 4;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_ODD_WIDE = 3'd4
  } status_e;

  // One dedup table slot
  typedef struct packed {
    logic             vld;
    logic [63:0]      tag;
    logic [OFS_W-1:0] ofs;
  } dedup_entry_t;

  // One FNV-1a step: xor the byte, multiply by the prime 2^40 + 0x1B3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

// ===== design/dspa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dspa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read of the address being written returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/dedup_string_pool_appender.sv =====
// Deduplicating string pool appender: FNV-1a hashing, pool writes, dedup lookup and commit.
// Depends on dspa_pkg, dspa_ram and dedup_string_pool_appender_assert.svh.
//
//  Channel   | Direction | Transaction
//  ----------+-----------+-------------------------------------------------------
//  s_axis    | in        | one string byte; tlast on final byte; tuser = wide flag
//  m_axis    | out       | one result per string; tuser = status
//  cfg       | in        | pool_bytes write, taken at every edge with cfg_we_i high
//
// One byte is taken per cycle while s_axis_tready is high. The hash advances in the accept
// cycle; the byte is written to the pool from stage 1 and, on the final byte, the dedup slot
// is checked and committed there, and the result is valid in the cycle after the commit.
// After reset the dedup table is cleared one slot per cycle, with s_axis_tready low until
// every slot is cleared.
// s_axis_tready stays low while a finished string waits for the receiver to take the
// result held in the output register. DEDUP_ENTRIES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module dedup_string_pool_appender
  import dspa_pkg::*;
#(
  parameter int unsigned POOL_DEPTH     = 65536,
  parameter int unsigned DEDUP_ENTRIES  = 1024,
  parameter int unsigned MAX_NARROW_LEN = 65535,
  parameter int unsigned MAX_WIDE_LEN   = 32767,
  parameter int unsigned HEADER_BYTES   = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [LEN_W-1:0]  cfg_wdata_i,     // pool_bytes
  // input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,    // [7:0] data_byte
  input  wire logic              s_axis_tlast,    // last_byte
  input  wire logic              s_axis_tuser,    // [0] wide_text
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [47:0]            m_axis_tdata,    // [15:0] string_offset,
                                                  // [32:16] used_after,
                                                  // [47:33] count_after
  output logic [2:0]             m_axis_tuser     // [2:0] status
);

  `include "dedup_string_pool_appender_assert.svh"

  localparam int unsigned IDX_W      = $clog2(DEDUP_ENTRIES);
  localparam int unsigned BANK_DEPTH = (POOL_DEPTH + POOL_BANKS - 1) / POOL_BANKS;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
  localparam logic [LIM_W-1:0] POOL_LIM     = LIM_W'(POOL_DEPTH);
  localparam logic [LEN_W-1:0] NARROW_LIM   = LEN_W'(MAX_NARROW_LEN);
  localparam logic [LEN_W-1:0] WIDE_LIM     = LEN_W'(2 * MAX_WIDE_LEN);
  localparam logic [LEN_W-1:0] USED_RST     = LEN_W'(HEADER_BYTES);
  localparam logic [IDX_W-1:0] LAST_SLOT    = IDX_W'(DEDUP_ENTRIES - 1);
  localparam logic [OFS_W-1:0] HEADER_OFS   = OFS_W'(HEADER_BYTES);

  // Architectural state
  logic [LEN_W-1:0] pool_bytes_q;
  logic [LEN_W-1:0] used_mark_q, used_mark_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [63:0]      hash_q, hash_d;
  logic [LEN_W-1:0] len_q, len_d;

  // Table clearing pass after reset
  logic             clr_q;
  logic [IDX_W-1:0] clr_idx_q;

  // Stage 1: byte in flight to the pool, lookup result arriving from the table
  logic             s1_vld_q;
  logic             s1_last_q;
  logic             s1_wide_q;
  logic [7:0]       s1_byte_q;
  logic [LEN_W-1:0] s1_idx_q;
  logic [63:0]      s1_hash_q;

  // Output register
  logic             out_vld_q, out_vld_d;
  status_e          out_status_q;
  logic [OFS_W-1:0] out_ofs_q;
  logic [LEN_W-1:0] out_used_q;
  logic [CNT_W-1:0] out_cnt_q;

  // Last table insert, forwarded to a lookup that read the slot at the same edge
  logic             fwd_vld_q;
  logic [IDX_W-1:0] fwd_slot_q;
  dedup_entry_t     fwd_entry_q;

  // Handshakes
  logic        in_fire;
  logic        s1_fire;
  logic [63:0] hash_step;

  assign s_axis_tready = !clr_q && (!s1_vld_q || s1_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s1_fire       = s1_vld_q && (!s1_last_q || !out_vld_q || m_axis_tready);
  assign hash_step     = fnv_step(hash_q, s_axis_tdata);

  // Running hash and byte count of the string being received
  always_comb begin
    hash_d = hash_q;
    len_d  = len_q;
    if (in_fire) begin
      if (s_axis_tlast) begin
        hash_d = FNV_BASIS;
        len_d  = '0;
      end else begin
        hash_d = hash_step;
        len_d  = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);
      end
    end
  end

  // Stage 1 address and length math; used_mark_q already holds every earlier commit
  logic [LEN_W-1:0]  s1_len;
  logic [LEN_W:0]    s1_base;
  logic [ADDR_W-1:0] byte_addr, zero1_addr, zero2_addr, new_used;
  logic [IDX_W-1:0]  s1_slot;

  assign s1_len     = (s1_idx_q == LEN_MAX) ? LEN_MAX : s1_idx_q + LEN_W'(1);
  assign s1_base    = {1'b0, used_mark_q} + {{LEN_W{1'b0}}, s1_wide_q & used_mark_q[0]};
  assign byte_addr  = ADDR_W'(s1_base) + ADDR_W'(s1_idx_q);
  assign zero1_addr = byte_addr + ADDR_W'(1);
  assign zero2_addr = byte_addr + ADDR_W'(2);
  assign new_used   = ADDR_W'(s1_base) + ADDR_W'(s1_len)
                    + (s1_wide_q ? ADDR_W'(2) : ADDR_W'(1));
  assign s1_slot    = s1_hash_q[IDX_W-1:0];

  // Dedup table lookup with forwarding of the latest insert
  logic [$bits(dedup_entry_t)-1:0] tbl_rdata;
  dedup_entry_t tbl_entry;
  logic         s1_hit;

  always_comb begin
    if (fwd_vld_q && fwd_slot_q == s1_slot) begin
      tbl_entry = fwd_entry_q;
    end else begin
      tbl_entry = dedup_entry_t'(tbl_rdata);
    end
  end
  assign s1_hit = tbl_entry.vld && (tbl_entry.tag == s1_hash_q);

  // Checks and result of a finished string
  logic             too_long, odd_wide, no_space, s1_commit;
  status_e          s1_status;
  logic [OFS_W-1:0] s1_ofs;

  assign too_long = s1_wide_q ? (s1_len > WIDE_LIM) : (s1_len > NARROW_LIM);
  assign odd_wide = s1_wide_q & s1_len[0];
  assign no_space = (new_used > ADDR_W'(pool_bytes_q))
                 || ({2'b00, new_used} > POOL_LIM)
                 || (s1_base[LEN_W:OFS_W] != '0);

  always_comb begin
    s1_status = ST_ADDED;
    s1_ofs    = s1_base[OFS_W-1:0];
    if (too_long) begin
      s1_status = ST_TOO_LONG;
      s1_ofs    = '0;
    end else if (odd_wide) begin
      s1_status = ST_ODD_WIDE;
      s1_ofs    = '0;
    end else if (s1_hit) begin
      s1_status = ST_DUP;
      s1_ofs    = tbl_entry.ofs;
    end else if (no_space) begin
      s1_status = ST_NO_SPACE;
      s1_ofs    = '0;
    end
  end

  assign s1_commit = s1_last_q && (s1_status == ST_ADDED);

  // Commit of used mark and string count
  always_comb begin
    used_mark_d = used_mark_q;
    count_d     = count_q;
    if (s1_fire && s1_commit) begin
      used_mark_d = new_used[LEN_W-1:0];
      count_d     = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
    end
  end

  // Table write port: clearing pass, or insert into a free slot
  logic         tbl_ins;
  logic         tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  dedup_entry_t tbl_wentry;

  assign tbl_ins = s1_fire && s1_commit && !tbl_entry.vld;

  always_comb begin
    tbl_wentry.vld = 1'b1;
    tbl_wentry.tag = s1_hash_q;
    tbl_wentry.ofs = s1_base[OFS_W-1:0];
    tbl_waddr      = s1_slot;
    tbl_we         = tbl_ins;
    if (clr_q) begin
      tbl_wentry = '0;
      tbl_waddr  = clr_idx_q;
      tbl_we     = 1'b1;
    end
  end

  dspa_ram #(
    .WIDTH ($bits(dedup_entry_t)),
    .DEPTH (DEDUP_ENTRIES)
  ) u_dedup_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wentry),
    .re_i    (in_fire),
    .raddr_i (hash_step[IDX_W-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Pool banks: the byte, and zeros ahead of it that become the terminator
  for (genvar k = 0; k < POOL_BANKS; k++) begin : g_bank
    logic               bank_we;
    logic [BANK_AW-1:0] bank_waddr;
    logic [7:0]         bank_wdata;
    logic [ADDR_W-1:0]  bank_addr;

    always_comb begin
      bank_we    = 1'b0;
      bank_addr  = byte_addr;
      bank_wdata = 8'd0;
      if (byte_addr[1:0] == 2'(k)) begin
        bank_we    = 1'b1;
        bank_wdata = s1_byte_q;
      end else if (zero1_addr[1:0] == 2'(k)) begin
        bank_we   = 1'b1;
        bank_addr = zero1_addr;
      end else if (s1_wide_q && zero2_addr[1:0] == 2'(k)) begin
        bank_we   = 1'b1;
        bank_addr = zero2_addr;
      end
      bank_we    = bank_we && s1_fire && ({2'b00, bank_addr} < POOL_LIM);
      bank_waddr = BANK_AW'(bank_addr >> 2);
    end

    dspa_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_pool_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .re_i    (1'b0),
      .raddr_i ('0),
      .rdata_o ()
    );
  end

  // Output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_fire && s1_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_bytes_q <= POOL_BYTES_RST;
      used_mark_q  <= USED_RST;
      count_q      <= '0;
      hash_q       <= FNV_BASIS;
      len_q        <= '0;
      clr_q        <= 1'b1;
      clr_idx_q    <= '0;
      s1_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      fwd_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_bytes_q <= cfg_wdata_i;
      end
      used_mark_q <= used_mark_d;
      count_q     <= count_d;
      hash_q      <= hash_d;
      len_q       <= len_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == LAST_SLOT) begin
          clr_q <= 1'b0;
        end
      end
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      out_vld_q <= out_vld_d;
      if (tbl_ins) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q <= s_axis_tlast;
      s1_wide_q <= s_axis_tuser;
      s1_byte_q <= s_axis_tdata;
      s1_idx_q  <= len_q;
      s1_hash_q <= hash_step;
    end
    if (s1_fire && s1_last_q) begin
      out_status_q <= s1_status;
      out_ofs_q    <= s1_ofs;
      out_used_q   <= used_mark_d;
      out_cnt_q    <= count_d;
    end
    if (tbl_ins) begin
      fwd_slot_q  <= s1_slot;
      fwd_entry_q <= tbl_wentry;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_cnt_q, out_used_q, out_ofs_q};
  assign m_axis_tuser  = out_status_q;

  // Checks
  `DSPA_ASSERT_NOW(a_no_accept_in_clear, clr_q, !s_axis_tready,
    "byte accepted during dedup table clearing")
  `DSPA_ASSERT_NOW(a_result_slot_free, s1_fire && s1_last_q, !out_vld_q || m_axis_tready,
    "result overwrote a pending output transaction")
  `DSPA_ASSERT_NEXT(a_commit_grows, s1_fire && s1_commit, used_mark_q > $past(used_mark_q),
    "commit did not advance the used mark")
  `DSPA_ASSERT_NOW(a_offset_past_header,
    out_vld_q && (out_status_q == ST_ADDED || out_status_q == ST_DUP),
    out_ofs_q >= HEADER_OFS,
    "stored string offset lies inside the header")

endmodule

`default_nettype wire
